@@ hdl/epi_pkg.sv @@
// Shared widths, register codes and reset values for the epipolar inlier test.
package epi_pkg;

  // Default point and coefficient widths.
  localparam int COORD_WIDTH_DEF = 20;
  localparam int COEF_WIDTH_DEF  = 21;

  // Configuration register widths and reset values.
  localparam int ROW_W      = 63;
  localparam int THR_W      = 20;
  localparam int THR_RESET  = 65536;
  localparam int CFG_IDX_W  = 3;

  // Epipolar line components are Q.16. The coefficient sum is bounded by
  // 3 * 2^21 after rounding for every legal width, so 25 signed bits hold it.
  localparam int LINE_FRAC = 16;
  localparam int LINE_W    = 25;

  // Sum of squares, root and algebraic distance widths.
  localparam int SQ_W       = 2 * LINE_W;
  localparam int ROOT_W     = LINE_W;
  localparam int D_W        = LINE_W + 6;
  localparam int ROOT_STEPS = LINE_W;
  localparam int ROOT_SPS   = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_F_ROW0    = 3'd0,
    REG_F_ROW1    = 3'd1,
    REG_F_ROW2    = 3'd2,
    REG_THRESHOLD = 3'd3
  } cfg_reg_t;

endpackage

@@ hdl/epi_line.sv @@
// Epipolar lines, algebraic distance and squared line norms over four stages.
module epi_line #(
  parameter int COORD_W = epi_pkg::COORD_WIDTH_DEF,
  parameter int COEF_W  = epi_pkg::COEF_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [COORD_W-1:0]         x1,
  input  logic signed [COORD_W-1:0]         y1,
  input  logic signed [COORD_W-1:0]         x2,
  input  logic signed [COORD_W-1:0]         y2,
  input  logic        [epi_pkg::ROW_W-1:0]  f_row [3],
  output logic                              out_valid,
  output logic signed [epi_pkg::D_W-1:0]    d,
  output logic        [epi_pkg::SQ_W-1:0]   sq1,
  output logic        [epi_pkg::SQ_W-1:0]   sq2
);

  localparam int LINE_W     = epi_pkg::LINE_W;
  localparam int COORD_FRAC = COORD_W - 4;
  localparam int COEF_FRAC  = COEF_W - 3;
  localparam int LSHIFT     = COORD_FRAC + COEF_FRAC - epi_pkg::LINE_FRAC;
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int DP_W       = COORD_W + LINE_W;
  localparam int DR_W       = DP_W - COORD_FRAC;
  localparam logic signed [SUM_W-1:0] L_HALF = SUM_W'(1) << (LSHIFT - 1);
  localparam logic signed [DP_W-1:0]  D_HALF = DP_W'(1) << (COORD_FRAC - 1);

  // Round to nearest, ties away from zero, and drop the extra fraction bits.
  function automatic logic signed [LINE_W-1:0] rnd_line(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s + (s[SUM_W-1] ? (L_HALF - SUM_W'(1)) : L_HALF);
    return LINE_W'(t >>> LSHIFT);
  endfunction

  function automatic logic signed [DR_W-1:0] rnd_dist(input logic signed [DP_W-1:0] s);
    logic signed [DP_W-1:0] t;
    t = s + (s[DP_W-1] ? (D_HALF - DP_W'(1)) : D_HALF);
    return DR_W'(t >>> COORD_FRAC);
  endfunction

  logic signed [COEF_W-1:0] c [3][3];

  // Unpack the matrix coefficients from the row registers.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        c[r][k] = f_row[r][k*COEF_W +: COEF_W];
      end
    end
  end

  // Stage A: coefficient times coordinate products.
  logic                     va_r;
  logic signed [PROD_W-1:0] m1_r [4];
  logic signed [PROD_W-1:0] m2_r [6];
  logic signed [COORD_W-1:0] xa_r, ya_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r[0] <= c[0][0] * x1;
      m1_r[1] <= c[0][1] * y1;
      m1_r[2] <= c[1][0] * x1;
      m1_r[3] <= c[1][1] * y1;
      for (int i = 0; i < 3; i++) begin
        m2_r[2*i]   <= c[0][i] * x2;
        m2_r[2*i+1] <= c[1][i] * y2;
      end
      xa_r <= x1;
      ya_r <= y1;
    end
  end

  // Stage B: line components, rounded to Q.16.
  logic                      vb_r;
  logic signed [LINE_W-1:0]  l1x_r, l1y_r, l2x_r, l2y_r, l2z_r;
  logic signed [COORD_W-1:0] xb_r, yb_r;
  logic signed [SUM_W-1:0]   s1x, s1y, s2x, s2y, s2z;

  always_comb begin
    s1x = SUM_W'(m1_r[0]) + SUM_W'(m1_r[1]) + (SUM_W'(c[0][2]) <<< COORD_FRAC);
    s1y = SUM_W'(m1_r[2]) + SUM_W'(m1_r[3]) + (SUM_W'(c[1][2]) <<< COORD_FRAC);
    s2x = SUM_W'(m2_r[0]) + SUM_W'(m2_r[1]) + (SUM_W'(c[2][0]) <<< COORD_FRAC);
    s2y = SUM_W'(m2_r[2]) + SUM_W'(m2_r[3]) + (SUM_W'(c[2][1]) <<< COORD_FRAC);
    s2z = SUM_W'(m2_r[4]) + SUM_W'(m2_r[5]) + (SUM_W'(c[2][2]) <<< COORD_FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1x_r <= rnd_line(s1x);
      l1y_r <= rnd_line(s1y);
      l2x_r <= rnd_line(s2x);
      l2y_r <= rnd_line(s2y);
      l2z_r <= rnd_line(s2z);
      xb_r  <= xa_r;
      yb_r  <= ya_r;
    end
  end

  // Stage C: point-line products and squared line components.
  logic                       vc_r;
  logic signed [DP_W-1:0]     dx_r, dy_r;
  logic signed [LINE_W-1:0]   l2z_c_r;
  logic signed [2*LINE_W-1:0] q1x_r, q1y_r, q2x_r, q2y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r    <= xb_r * l2x_r;
      dy_r    <= yb_r * l2y_r;
      l2z_c_r <= l2z_r;
      q1x_r   <= l1x_r * l1x_r;
      q1y_r   <= l1y_r * l1y_r;
      q2x_r   <= l2x_r * l2x_r;
      q2y_r   <= l2y_r * l2y_r;
    end
  end

  // Stage D: algebraic distance and sums of squares.
  logic                              vd_r;
  logic signed [epi_pkg::D_W-1:0]    d_r;
  logic        [epi_pkg::SQ_W-1:0]   sq1_r, sq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (adv) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r   <= epi_pkg::D_W'(rnd_dist(dx_r)) + epi_pkg::D_W'(rnd_dist(dy_r))
             + epi_pkg::D_W'(l2z_c_r);
      sq1_r <= $unsigned(q1x_r) + $unsigned(q1y_r);
      sq2_r <= $unsigned(q2x_r) + $unsigned(q2y_r);
    end
  end

  assign out_valid = vd_r;
  assign d         = d_r;
  assign sq1       = sq1_r;
  assign sq2       = sq2_r;

endmodule

@@ hdl/epi_sqrt.sv @@
// Pipelined digit-by-digit square roots of both line norms, two digits a stage.
module epi_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic        [epi_pkg::SQ_W-1:0]  sq1,
  input  logic        [epi_pkg::SQ_W-1:0]  sq2,
  input  logic signed [epi_pkg::D_W-1:0]   d_in,
  output logic                             out_valid,
  output logic        [epi_pkg::ROOT_W-1:0] n1,
  output logic        [epi_pkg::ROOT_W-1:0] n2,
  output logic signed [epi_pkg::D_W-1:0]   d_out
);

  localparam int SQ_W  = epi_pkg::SQ_W;
  localparam int STEPS = epi_pkg::ROOT_STEPS;
  localparam int SPS   = epi_pkg::ROOT_SPS;
  localparam int NST   = (STEPS + SPS - 1) / SPS;

  // One restoring step: try the current bit against the remainder.
  function automatic logic [2*SQ_W-1:0] root_step(input logic [SQ_W-1:0] a,
                                                  input logic [SQ_W-1:0] res,
                                                  input logic [SQ_W-1:0] b);
    logic [SQ_W-1:0] t;
    t = res + b;
    if (a >= t) begin
      return {a - t, (res >> 1) + b};
    end
    return {a, res >> 1};
  endfunction

  logic                            v_r  [NST];
  logic        [SQ_W-1:0]          a1_r [NST];
  logic        [SQ_W-1:0]          r1_r [NST];
  logic        [SQ_W-1:0]          a2_r [NST];
  logic        [SQ_W-1:0]          r2_r [NST];
  logic signed [epi_pkg::D_W-1:0]  d_r  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic                           v_in;
    logic        [SQ_W-1:0]         a1_in, r1_in, a2_in, r2_in;
    logic signed [epi_pkg::D_W-1:0] d_src;
    logic        [SQ_W-1:0]         a1_nxt, r1_nxt, a2_nxt, r2_nxt;

    // Stage inputs come from the ports or from the previous stage.
    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign a1_in = sq1;
      assign r1_in = '0;
      assign a2_in = sq2;
      assign r2_in = '0;
      assign d_src = d_in;
    end else begin : g_next
      assign v_in  = v_r[s-1];
      assign a1_in = a1_r[s-1];
      assign r1_in = r1_r[s-1];
      assign a2_in = a2_r[s-1];
      assign r2_in = r2_r[s-1];
      assign d_src = d_r[s-1];
    end

    // Up to two root digits per stage; the last stage may take fewer.
    always_comb begin
      int k;
      logic [SQ_W-1:0] b;
      a1_nxt = a1_in;
      r1_nxt = r1_in;
      a2_nxt = a2_in;
      r2_nxt = r2_in;
      for (int j = 0; j < SPS; j++) begin
        k = s * SPS + j;
        if (k < STEPS) begin
          b = SQ_W'(1) << (2 * (STEPS - 1 - k));
          {a1_nxt, r1_nxt} = root_step(a1_nxt, r1_nxt, b);
          {a2_nxt, r2_nxt} = root_step(a2_nxt, r2_nxt, b);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a1_r[s] <= a1_nxt;
        r1_r[s] <= r1_nxt;
        a2_r[s] <= a2_nxt;
        r2_r[s] <= r2_nxt;
        d_r[s]  <= d_src;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign n1        = r1_r[NST-1][epi_pkg::ROOT_W-1:0];
  assign n2        = r2_r[NST-1][epi_pkg::ROOT_W-1:0];
  assign d_out     = d_r[NST-1];

endmodule

@@ hdl/epi_score.sv @@
// Cross-multiplied distance test against the threshold, with the output register.
module epi_score (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [epi_pkg::D_W-1:0]    d,
  input  logic        [epi_pkg::ROOT_W-1:0] n1,
  input  logic        [epi_pkg::ROOT_W-1:0] n2,
  input  logic        [epi_pkg::THR_W-1:0]  thr,
  output logic                              out_valid,
  output logic                              is_inlier
);

  localparam int D_W   = epi_pkg::D_W;
  localparam int RW    = epi_pkg::ROOT_W;
  localparam int THR_W = epi_pkg::THR_W;
  localparam int LHS_W = D_W + RW + 1;
  localparam int RHS_W = THR_W + 2 * RW;
  localparam int SH_W  = LHS_W + epi_pkg::LINE_FRAC;
  localparam int CMP_W = (SH_W > RHS_W) ? SH_W : RHS_W;

  // Stage 1: distance magnitude, norm sum and the degenerate-line flag.
  logic            v1_r, z1_r;
  logic [D_W-1:0]  ad1_r;
  logic [RW:0]     s1_r;
  logic [RW-1:0]   n1_r, n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ad1_r <= d[D_W-1] ? D_W'(-d) : D_W'(d);
      s1_r  <= {1'b0, n1} + {1'b0, n2};
      n1_r  <= n1;
      n2_r  <= n2;
      z1_r  <= (n1 == '0) || (n2 == '0);
    end
  end

  // Stage 2: left side product and the product of the norms.
  logic              v2_r, z2_r;
  logic [LHS_W-1:0]  lhs2_r;
  logic [2*RW-1:0]   prod2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lhs2_r  <= LHS_W'(ad1_r) * LHS_W'(s1_r);
      prod2_r <= (2*RW)'(n1_r) * (2*RW)'(n2_r);
      z2_r    <= z1_r;
    end
  end

  // Stage 3: threshold times each half of the norm product.
  logic                 v3_r, z3_r;
  logic [LHS_W-1:0]     lhs3_r;
  logic [THR_W+RW-1:0]  rl3_r, rh3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rl3_r  <= (THR_W+RW)'(thr) * (THR_W+RW)'(prod2_r[RW-1:0]);
      rh3_r  <= (THR_W+RW)'(thr) * (THR_W+RW)'(prod2_r[2*RW-1:RW]);
      lhs3_r <= lhs2_r;
      z3_r   <= z2_r;
    end
  end

  // Stage 4: assemble the right side.
  logic              v4_r, z4_r;
  logic [LHS_W-1:0]  lhs4_r;
  logic [RHS_W-1:0]  rhs4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rhs4_r <= (RHS_W'(rh3_r) << RW) + RHS_W'(rl3_r);
      lhs4_r <= lhs3_r;
      z4_r   <= z3_r;
    end
  end

  // Stage 5: strict compare into the output register.
  logic v5_r, inl5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inl5_r <= !z4_r &&
                ((CMP_W'(lhs4_r) << epi_pkg::LINE_FRAC) < CMP_W'(rhs4_r));
    end
  end

  assign out_valid = v5_r;
  assign is_inlier = inl5_r;

endmodule

@@ hdl/epipolar_inlier_test.sv @@
// Top level of the symmetric epipolar distance inlier test.
// One correspondence is taken per cycle unless a result waits on out_stall, and
// its inlier flag passes one input register, four stages for the epipolar lines
// and the algebraic distance, thirteen stages of the two-digit-per-stage
// square root that forms both line norms, and five stages for the
// cross-multiplied threshold compare, the last being the output register.
// While a result waits on out_stall the whole pipeline holds and in_stall is
// raised; otherwise a new pair is taken every cycle. A line with zero norm
// gives an outlier. Matrix rows and the threshold are written through the
// configuration port, which is always ready and is meant to be used only
// while no pair is in flight.
module epipolar_inlier_test #(
  parameter int COORD_WIDTH = epi_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = epi_pkg::COEF_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        in_first_x,
  input  logic signed [COORD_WIDTH-1:0]        in_first_y,
  input  logic signed [COORD_WIDTH-1:0]        in_second_x,
  input  logic signed [COORD_WIDTH-1:0]        in_second_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_is_inlier,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [epi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [epi_pkg::ROW_W-1:0]     cfg_data
);

  logic                        adv;
  logic [epi_pkg::ROW_W-1:0]   f_row_r [3];
  logic [epi_pkg::THR_W-1:0]   thr_r;

  // The pipeline moves whenever the output register is free to move.
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_row_r[0] <= '0;
      f_row_r[1] <= '0;
      f_row_r[2] <= '0;
      thr_r      <= epi_pkg::THR_W'(epi_pkg::THR_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (epi_pkg::cfg_reg_t'(cfg_index))
        epi_pkg::REG_F_ROW0:    f_row_r[0] <= cfg_data;
        epi_pkg::REG_F_ROW1:    f_row_r[1] <= cfg_data;
        epi_pkg::REG_F_ROW2:    f_row_r[2] <= cfg_data;
        epi_pkg::REG_THRESHOLD: thr_r      <= cfg_data[epi_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register for each transfer.
  logic                         v0_r;
  logic signed [COORD_WIDTH-1:0] x1_r, y1_r, x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r <= in_first_x;
      y1_r <= in_first_y;
      x2_r <= in_second_x;
      y2_r <= in_second_y;
    end
  end

  logic                                 line_valid;
  logic signed [epi_pkg::D_W-1:0]       line_d;
  logic        [epi_pkg::SQ_W-1:0]      line_sq1, line_sq2;
  logic                                 root_valid;
  logic        [epi_pkg::ROOT_W-1:0]    root_n1, root_n2;
  logic signed [epi_pkg::D_W-1:0]       root_d;

  epi_line #(
    .COORD_W (COORD_WIDTH),
    .COEF_W  (COEF_WIDTH)
  ) u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v0_r),
    .x1        (x1_r),
    .y1        (y1_r),
    .x2        (x2_r),
    .y2        (y2_r),
    .f_row     (f_row_r),
    .out_valid (line_valid),
    .d         (line_d),
    .sq1       (line_sq1),
    .sq2       (line_sq2)
  );

  epi_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (line_valid),
    .sq1       (line_sq1),
    .sq2       (line_sq2),
    .d_in      (line_d),
    .out_valid (root_valid),
    .n1        (root_n1),
    .n2        (root_n2),
    .d_out     (root_d)
  );

  epi_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (root_valid),
    .d         (root_d),
    .n1        (root_n1),
    .n2        (root_n2),
    .thr       (thr_r),
    .out_valid (out_valid),
    .is_inlier (out_is_inlier)
  );

endmodule

@@ hdl/epi_checker.sv @@
// Port-level assertions for the epipolar inlier test, bound to the top level.
module epi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_is_inlier
);

  // Reset empties the pipeline by the next edge.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // The input side is held back only by a stalled result.
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_is_inlier)))
    else $error("stalled result changed or dropped");

  // An input seen while the output is empty is never stalled.
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !out_valid) |-> !in_stall)
    else $error("input stalled while output empty");

endmodule

bind epipolar_inlier_test epi_checker u_epi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_is_inlier (out_is_inlier)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the symmetric epipolar distance inlier test.
module tb_top;

  localparam int CW = epi_pkg::COORD_WIDTH_DEF;
  localparam int KW = epi_pkg::COEF_WIDTH_DEF;
  localparam logic [epi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;

  // Scoreboard: holds the register copy, predicts each flag and checks results.
  class inlier_scoreboard;
    logic [epi_pkg::ROW_W-1:0] f_rows [3];
    logic [epi_pkg::THR_W-1:0] thr;
    bit expected_flags [$];
    int errors;

    function new();
      f_rows[0] = '0;
      f_rows[1] = '0;
      f_rows[2] = '0;
      thr = epi_pkg::THR_W'(epi_pkg::THR_RESET);
      errors = 0;
    endfunction

    function void write_reg(logic [epi_pkg::CFG_IDX_W-1:0] idx,
                            logic [epi_pkg::ROW_W-1:0] value);
      case (idx)
        epi_pkg::REG_F_ROW0: f_rows[0] = value;
        epi_pkg::REG_F_ROW1: f_rows[1] = value;
        epi_pkg::REG_F_ROW2: f_rows[2] = value;
        epi_pkg::REG_THRESHOLD: thr = value[epi_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint coef_at(int r, int c);
      logic signed [KW-1:0] k;
      k = f_rows[r][c*KW +: KW];
      return longint'(k);
    endfunction

    // Rounds to nearest on the magnitude, so ties go away from zero.
    function longint round_off(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (s - 1))) >>> s;
      return (v < 0) ? -m : m;
    endfunction

    function longint clamp_line(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
    endfunction

    function longint unsigned floor_root(longint unsigned a);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= a) r = t;
      end
      return r;
    endfunction

    function bit predict_inlier(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                                logic signed [CW-1:0] x2, logic signed [CW-1:0] y2);
      longint p1 [3];
      longint p2 [3];
      longint l1 [3];
      longint l2 [3];
      longint s1, s2, d;
      longint unsigned n1, n2, ad;
      logic [127:0] lhs, rhs;
      p1[0] = x1;
      p1[1] = y1;
      p1[2] = longint'(1) << (CW - 4);
      p2[0] = x2;
      p2[1] = y2;
      p2[2] = longint'(1) << (CW - 4);
      // Epipolar lines in both images, rounded to Q.16 and clamped.
      for (int i = 0; i < 3; i++) begin
        s1 = 0;
        s2 = 0;
        for (int j = 0; j < 3; j++) begin
          s1 += coef_at(i, j) * p1[j];
          s2 += coef_at(j, i) * p2[j];
        end
        l1[i] = clamp_line(round_off(s1, (CW - 4) + (KW - 3) - epi_pkg::LINE_FRAC));
        l2[i] = clamp_line(round_off(s2, (CW - 4) + (KW - 3) - epi_pkg::LINE_FRAC));
      end
      // Algebraic distance with each product rounded separately.
      d = 0;
      for (int j = 0; j < 3; j++) d += round_off(p1[j] * l2[j], CW - 4);
      n1 = floor_root(longint'(l1[0] * l1[0]) + longint'(l1[1] * l1[1]));
      n2 = floor_root(longint'(l2[0] * l2[0]) + longint'(l2[1] * l2[1]));
      // A degenerate line means an unbounded distance.
      if (n1 == 0 || n2 == 0) return 1'b0;
      ad = (d < 0) ? -d : d;
      lhs = 128'(ad) * 128'(n1 + n2);
      lhs = lhs << epi_pkg::LINE_FRAC;
      rhs = 128'(thr) * 128'(n1) * 128'(n2);
      return lhs < rhs;
    endfunction

    function void note_input(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                             logic signed [CW-1:0] x2, logic signed [CW-1:0] y2);
      expected_flags = {expected_flags, predict_inlier(x1, y1, x2, y2)};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(bit flag);
      bit want;
      if (expected_flags.size() == 0) begin
        report($sformatf("unexpected result is_inlier=%0b", flag));
        return;
      end
      want = expected_flags.pop_front();
      if (flag !== want) report($sformatf("is_inlier got %0b want %0b", flag, want));
    endtask

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_first_x = '0;
  logic signed [CW-1:0] in_first_y = '0;
  logic signed [CW-1:0] in_second_x = '0;
  logic signed [CW-1:0] in_second_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_inlier;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [epi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [epi_pkg::ROW_W-1:0] cfg_data = '0;

  inlier_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  epipolar_inlier_test u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_is_inlier(out_is_inlier),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_is_inlier);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("epipolar_inlier_test regression: fail");
      $finish;
    end
  end

  function automatic logic [epi_pkg::ROW_W-1:0] pack_row(int c0, int c1, int c2);
    logic [KW-1:0] a, b, c;
    a = c0[KW-1:0];
    b = c1[KW-1:0];
    c = c2[KW-1:0];
    return {c, b, a};
  endfunction

  function automatic int rand_signed(int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // One register write transfer; the scoreboard copy follows it.
  task automatic write_cfg(logic [epi_pkg::CFG_IDX_W-1:0] idx,
                           logic [epi_pkg::ROW_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for the pipeline to drain before touching the registers.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_matrix(logic [epi_pkg::ROW_W-1:0] r0, logic [epi_pkg::ROW_W-1:0] r1,
                             logic [epi_pkg::ROW_W-1:0] r2, logic [epi_pkg::THR_W-1:0] t);
    drain();
    write_cfg(epi_pkg::REG_F_ROW0, r0);
    write_cfg(epi_pkg::REG_F_ROW1, r1);
    write_cfg(epi_pkg::REG_F_ROW2, r2);
    write_cfg(epi_pkg::REG_THRESHOLD, epi_pkg::ROW_W'(t));
  endtask

  // Sends one correspondence, with a random gap before it.
  task automatic send_pair(int x1, int y1, int x2, int y2);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_x <= x1[CW-1:0];
    in_first_y <= y1[CW-1:0];
    in_second_x <= x2[CW-1:0];
    in_second_y <= y2[CW-1:0];
    do @(posedge clk); while (in_stall);
    sb.note_input(x1[CW-1:0], y1[CW-1:0], x2[CW-1:0], y2[CW-1:0]);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly near-matching pairs, some pure noise.
  task automatic random_pairs(int count, int span);
    int x1, y1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 70) begin
        x1 = rand_signed(span);
        y1 = rand_signed(span);
        send_pair(x1, y1, x1 + rand_signed(512), y1 + rand_signed(512));
      end else begin
        send_pair(rand_signed(524288) - ($urandom_range(0, 1) ? 0 : 0),
                  int'($urandom_range(0, 1048575)) - 524288,
                  int'($urandom_range(0, 1048575)) - 524288,
                  int'($urandom_range(0, 1048575)) - 524288);
      end
    end
  endtask

  // Translation-only matrix [t]x: every pair with equal points has zero distance.
  task automatic load_translation(logic [epi_pkg::THR_W-1:0] t);
    int tx, ty, tz;
    tx = rand_signed(262144);
    ty = rand_signed(262144);
    tz = rand_signed(262144);
    load_matrix(pack_row(0, -tz, ty), pack_row(tz, 0, -tx), pack_row(-ty, tx, 0), t);
  endtask

  initial begin
    int thr_choice [4];
    thr_choice[0] = 65536;
    thr_choice[1] = 0;
    thr_choice[2] = 1048575;
    thr_choice[3] = 4096;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset matrix is zero, so every line is degenerate.
    send_pair(524287, -524288, 0, 0);
    send_pair(0, 0, 524287, 524287);
    send_pair(-524288, -524288, -524288, 524287);
    stop_sending();

    // Out-of-range index must leave the threshold alone.
    load_translation(20'd65536);
    write_cfg(REG_UNUSED, 63'h7FFF_FFFF_FFFF_FFFF);
    send_pair(0, 0, 0, 0);
    send_pair(65536, 32768, 65536, 32768);
    send_pair(524287, 524287, 524287, 524287);
    send_pair(-524288, -524288, -524288, -524288);
    send_pair(524287, -524288, -524288, 524287);
    send_pair(1000, 2000, 1000, 2300);
    stop_sending();

    // Extreme coefficients and extreme thresholds.
    load_matrix(pack_row(-1048576, 1048575, -1048576), pack_row(1048575, -1048576, 1048575),
                pack_row(-1048576, -1048576, 1048575), 20'd1048575);
    send_pair(524287, 524287, -524288, -524288);
    send_pair(-524288, 524287, 524287, -524288);
    send_pair(0, 0, 0, 0);
    send_pair(12345, -54321, 300, -700);
    stop_sending();
    load_translation(20'd0);
    send_pair(0, 0, 0, 0);
    send_pair(4096, 4096, 4096, 4096);
    stop_sending();

    // Matrix with a zero first column pair: lines in one image degenerate.
    load_matrix(pack_row(0, 0, 262144), pack_row(0, 0, 262144), pack_row(0, 0, 262144),
                20'd65536);
    send_pair(100, 200, 300, 400);
    send_pair(-524288, 524287, 0, 0);
    stop_sending();

    // Random phases under different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      load_translation(thr_choice[ph][epi_pkg::THR_W-1:0]);
      random_pairs(20, 131072);
      // Hold off until everything in flight has come back.
      if (ph == 0) begin
        stop_sending();
        while (sb.pending() != 0) @(posedge clk);
      end
      random_pairs(16, 524287);
      stop_sending();
      load_matrix(epi_pkg::ROW_W'({$urandom(), $urandom()}),
                  epi_pkg::ROW_W'({$urandom(), $urandom()}),
                  epi_pkg::ROW_W'({$urandom(), $urandom()}),
                  epi_pkg::THR_W'($urandom_range(0, 1048575)));
      random_pairs(36, 524287);
      stop_sending();
      load_translation(epi_pkg::THR_W'($urandom_range(256, 1048575)));
      random_pairs(36, 65536);
      stop_sending();
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("epipolar_inlier_test regression: pass");
    end else begin
      $display("epipolar_inlier_test regression: fail");
    end
    $finish;
  end

endmodule
